### hw/rtl/fltw_pkg.sv
package fltw_pkg;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BUSY = 2'd2
  } kind_e;

  // walk levels, also the size codes of a done word
  typedef enum logic [1:0] {
    LVL_PT   = 2'd0,
    LVL_PD   = 2'd1,
    LVL_PDPT = 2'd2,
    LVL_PML4 = 2'd3
  } level_e;

  // register map (byte address bit 3 selects the register)
  localparam logic REG_ROOT_FRAME = 1'b0;
  localparam logic REG_OFFSET     = 1'b1;

  localparam int unsigned VaWidth    = 48;
  localparam int unsigned FrameWidth = 40;
  localparam int unsigned PhysWidth  = 52;
  localparam int unsigned DataWidth  = 64;
  localparam int unsigned IdxWidth   = 9;

  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitHuge    = 7;

  // classified word held in the queue
  typedef struct packed {
    logic                 is_resp;
    logic [DataWidth-1:0] data;
  } item_t;

  // one result word
  typedef struct packed {
    kind_e                kind;
    logic [DataWidth-1:0] mem_addr;
    logic                 mapped;
    logic [1:0]           size_code;
    logic [PhysWidth-1:0] phys_addr;
    logic [DataWidth-1:0] leaf_entry;
  } result_t;

  // 9-bit table index of a virtual address at a level
  function automatic logic [IdxWidth-1:0] va_index(logic [VaWidth-1:0] va, level_e lvl);
    logic [IdxWidth-1:0] idx;
    idx = '0;
    unique case (lvl)
      LVL_PT:   idx = va[20:12];
      LVL_PD:   idx = va[29:21];
      LVL_PDPT: idx = va[38:30];
      LVL_PML4: idx = va[47:39];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

  // entry address: offset + frame * 4096 + index * 8, wrapping at 64 bits
  function automatic logic [DataWidth-1:0] entry_addr(logic [DataWidth-1:0] offset,
                                                      logic [FrameWidth-1:0] frame,
                                                      logic [IdxWidth-1:0] idx);
    return offset + {12'h000, frame, idx, 3'b000};
  endfunction

endpackage

### hw/rtl/four_level_page_table_walk.sv
// Four-level page table walker for 48-bit virtual addresses. A translate
// word (cmd 0) starts a walk and yields a read word (kind 0) with the
// address of the top-level entry; each memory response word (cmd 1) yields
// the next read word or a done word (kind 1) carrying mapped, size code,
// physical address and the raw leaf entry. A translate word during a walk
// gets a busy word (kind 2); a response word with no walk open gets nothing.
// Table addresses are table_access_offset + frame * 4096 + index * 8, mod
// 2^64. Throughput is one word per cycle while the output is not stalled:
// a two-entry queue sits between the input side and the walk unit, and
// the walk unit handles one word per cycle into a registered output stage.
// Results pass through the queue and output register. Registers (64-bit
// APB, byte addresses 0x0 root_table_frame, 0x8 table_access_offset) may be
// written only while no walk is open and no word is in flight.
module four_level_page_table_walk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [fltw_pkg::VaWidth-1:0]      virt_addr_i,
  input  logic [fltw_pkg::DataWidth-1:0]    read_data_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [fltw_pkg::DataWidth-1:0]    mem_addr_o,
  output logic                              mapped_o,
  output logic [1:0]                        size_code_o,
  output logic [fltw_pkg::PhysWidth-1:0]    phys_addr_o,
  output logic [fltw_pkg::DataWidth-1:0]    leaf_entry_o
);

  logic [fltw_pkg::FrameWidth-1:0] root_frame_q;
  logic [fltw_pkg::DataWidth-1:0]  offset_q;
  logic                            cfg_wr;
  logic                            head_valid;
  fltw_pkg::item_t                 head;
  logic                            pop;
  fltw_pkg::result_t               res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= '0;
      offset_q     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        fltw_pkg::REG_ROOT_FRAME: root_frame_q <= pwdata[fltw_pkg::FrameWidth-1:0];
        fltw_pkg::REG_OFFSET:     offset_q     <= pwdata;
        default:                  ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3])
      fltw_pkg::REG_ROOT_FRAME: prdata = {24'h000000, root_frame_q};
      fltw_pkg::REG_OFFSET:     prdata = offset_q;
      default:                  prdata = '0;
    endcase
  end

  fltw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .virt_addr_i  (virt_addr_i),
    .read_data_i  (read_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  fltw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .root_frame_i (root_frame_q),
    .offset_i     (offset_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign kind_o       = res.kind;
  assign mem_addr_o   = res.mem_addr;
  assign mapped_o     = res.mapped;
  assign size_code_o  = res.size_code;
  assign phys_addr_o  = res.phys_addr;
  assign leaf_entry_o = res.leaf_entry;

endmodule

### hw/rtl/fltw_front.sv
module fltw_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [fltw_pkg::VaWidth-1:0]      virt_addr_i,
  input  logic [fltw_pkg::DataWidth-1:0]    read_data_i,
  output logic                              head_valid_o,
  output fltw_pkg::item_t                   head_o,
  input  logic                              pop_i
);

  fltw_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  fltw_pkg::item_t item;

  // classify the incoming word: a request keeps only its address
  always_comb begin
    item.is_resp = cmd_i;
    if (cmd_i) begin
      item.data = read_data_i;
    end else begin
      item.data = {{(fltw_pkg::DataWidth - fltw_pkg::VaWidth){1'b0}}, virt_addr_i};
    end
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

### hw/rtl/fltw_back.sv
module fltw_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [fltw_pkg::FrameWidth-1:0]   root_frame_i,
  input  logic [fltw_pkg::DataWidth-1:0]    offset_i,
  input  logic                              head_valid_i,
  input  fltw_pkg::item_t                   head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fltw_pkg::result_t                 res_o
);

  logic                            busy_q, busy_d;
  fltw_pkg::level_e                level_q, level_d;
  logic [fltw_pkg::VaWidth-1:0]    saved_q, saved_d;
  logic                            out_valid_q, out_valid_d;
  fltw_pkg::result_t               res_q, res;
  logic                            has_res;
  logic [fltw_pkg::VaWidth-1:0]    req_va;
  logic                            present;
  logic                            huge;
  logic                            leaf;
  fltw_pkg::level_e                next_lvl;

  assign pop_o   = head_valid_i && (!out_valid_q || out_ready_i);
  assign req_va  = head_i.data[fltw_pkg::VaWidth-1:0];
  assign present = head_i.data[fltw_pkg::BitPresent];
  assign huge    = head_i.data[fltw_pkg::BitHuge];
  assign leaf    = (level_q == fltw_pkg::LVL_PT) ||
                   (huge && ((level_q == fltw_pkg::LVL_PD) ||
                             (level_q == fltw_pkg::LVL_PDPT)));
  assign next_lvl = fltw_pkg::level_e'(level_q - 2'd1);

  // walk step for the word at the head of the queue
  always_comb begin
    busy_d          = busy_q;
    level_d         = level_q;
    saved_d         = saved_q;
    has_res         = 1'b0;
    res.kind        = fltw_pkg::KIND_READ;
    res.mem_addr    = '0;
    res.mapped      = 1'b0;
    res.size_code   = 2'd0;
    res.phys_addr   = '0;
    res.leaf_entry  = '0;
    if (!head_i.is_resp) begin
      has_res = 1'b1;
      if (busy_q) begin
        res.kind = fltw_pkg::KIND_BUSY;
      end else begin
        busy_d       = 1'b1;
        level_d      = fltw_pkg::LVL_PML4;
        saved_d      = req_va;
        res.mem_addr = fltw_pkg::entry_addr(offset_i, root_frame_i,
                         fltw_pkg::va_index(req_va, fltw_pkg::LVL_PML4));
      end
    end else if (busy_q) begin
      has_res = 1'b1;
      if (!present) begin
        busy_d        = 1'b0;
        res.kind      = fltw_pkg::KIND_DONE;
        res.size_code = level_q;
      end else if (leaf) begin
        busy_d         = 1'b0;
        res.kind       = fltw_pkg::KIND_DONE;
        res.mapped     = 1'b1;
        res.size_code  = level_q;
        res.leaf_entry = head_i.data;
        unique case (level_q)
          fltw_pkg::LVL_PD:   res.phys_addr = {head_i.data[51:21], saved_q[20:0]};
          fltw_pkg::LVL_PDPT: res.phys_addr = {head_i.data[51:30], saved_q[29:0]};
          default:            res.phys_addr = {head_i.data[51:12], saved_q[11:0]};
        endcase
      end else begin
        level_d      = next_lvl;
        res.mem_addr = fltw_pkg::entry_addr(offset_i, head_i.data[51:12],
                         fltw_pkg::va_index(saved_q, next_lvl));
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && has_res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= fltw_pkg::LVL_PT;
      saved_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        busy_q  <= busy_d;
        level_q <= level_d;
        saved_q <= saved_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
